[rtl/scba_pkg.sv]
// Shared types, constants and helpers for the size class block allocator.
// No dependencies; the datapath, sequencer, top level and checker import it.
`default_nettype none
package scba_pkg;

  localparam int NUM_PAGES_DEF       = 64;
  localparam int PAGE_BYTES          = 4096;
  localparam int MAX_BLOCKS_PER_PAGE = 127;
  localparam int NUM_CLASSES         = 8;
  localparam int SLOT_W              = 7;
  localparam int CLS_W               = 3;

  localparam logic [6:0]  NONE_PTR  = 7'd127;
  localparam logic [11:0] DATA_OFS  = 12'd24;   // descriptor plus header
  localparam logic [13:0] HDR_BYTES = 14'd8;
  localparam logic [13:0] MAX_NEED  = 14'd4080;

  localparam logic [11:0] BLK_SIZE [NUM_CLASSES] = '{
    12'd32, 12'd64, 12'd128, 12'd252, 12'd508, 12'd1020, 12'd2040, 12'd4080
  };
  localparam logic [6:0] BLK_COUNT [NUM_CLASSES] = '{
    7'd127, 7'd63, 7'd31, 7'd16, 7'd8, 7'd4, 7'd2, 7'd1
  };

  typedef enum logic [2:0] {
    ST_OK            = 3'd0,
    ST_TOO_LARGE     = 3'd1,
    ST_NO_PAGE       = 3'd2,
    ST_BAD_POINTER   = 3'd3,
    ST_SIZE_MISMATCH = 3'd4
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE, S_A_HEAD, S_A_SCAN, S_A_THREAD, S_A_LINK, S_A_PRD, S_A_BRD, S_A_POP,
    S_F_CHK, S_F_PAGE, S_F_DIV, S_F_DCHK, S_F_BLK, S_F_WRD, S_F_WCHK, S_DONE
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LATCH, OP_ERR, OP_SEL_HEAD, OP_SCAN_START, OP_SCAN_NEXT,
    OP_SCAN_HIT, OP_THREAD, OP_LINK_NEW, OP_PAGE_RD, OP_BLK_RD_HEAD, OP_POP,
    OP_CAP_PAGE, OP_DIV_STEP, OP_BLK_RD_Q, OP_PUSH, OP_WALK_RD, OP_WALK_NEXT,
    OP_WALK_FIX, OP_RESULT
  } op_t;

  typedef struct packed {
    op_t     op;
    status_t err;
  } cmd_t;

  typedef struct packed {
    logic req_valid;
    logic req_free;
    logic too_big;
    logic head_none;
    logic scan_free;
    logic scan_last;
    logic thr_last;
    logic pg_ok;
    logic off_low;
    logic div_last;
    logic div_bad;
    logic blk_unused;
    logic len_bad;
    logic need_walk;
    logic walk_end;
    logic walk_hit;
    logic out_free;
  } stat_t;

  typedef struct packed {
    logic [CLS_W-1:0]  cls;
    logic [SLOT_W-1:0] free_count;
    logic [SLOT_W-1:0] block_head;
    logic [6:0]        link;
  } page_entry_t;

  typedef struct packed {
    logic [SLOT_W-1:0] link;
    logic              used;
    logic [12:0]       length;
  } block_entry_t;

  function automatic logic [CLS_W-1:0] class_of(input logic [12:0] size);
    logic [13:0]      need;
    logic [CLS_W-1:0] c;
    need = {1'b0, size} + HDR_BYTES;
    c = CLS_W'(NUM_CLASSES - 1);
    for (int i = NUM_CLASSES - 1; i >= 0; i--) begin
      if (need <= {2'b0, BLK_SIZE[i]}) c = CLS_W'(i);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

[rtl/scba_req_if.sv]
// Request channel: valid/ready plus the request payload.
// Standalone; no package needed.
`default_nettype none
interface scba_req_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [12:0] size_bytes;
  logic [17:0] block_address;
  modport source(output valid, mode, size_bytes, block_address, input ready);
  modport sink(input valid, mode, size_bytes, block_address, output ready);
endinterface
`default_nettype wire

[rtl/scba_rsp_if.sv]
// Response channel: valid/ready plus status and block address.
// Standalone; no package needed.
`default_nettype none
interface scba_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [17:0] address;
  modport source(output valid, status, address, input ready);
  modport sink(input valid, status, address, output ready);
endinterface
`default_nettype wire

[rtl/scba_ram.sv]
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`default_nettype none
module scba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[rtl/scba_datapath.sv]
// Allocator datapath: page and block tables, class list heads, divider, result.
// Depends on scba_pkg, scba_ram and the channel interfaces.
`default_nettype none
module scba_datapath #(
  parameter int NUM_PAGES = scba_pkg::NUM_PAGES_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire scba_pkg::cmd_t cmd,
  input  wire logic           in_ready,
  output scba_pkg::stat_t     st,
  scba_req_if.sink            req,
  scba_rsp_if.source          rsp
);
  import scba_pkg::*;

  localparam int PW = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
  localparam int BW = PW + SLOT_W;
  localparam logic [6:0] NP = 7'(NUM_PAGES);

  logic [12:0]       size_q;
  logic [17:0]       addr_q;
  logic [6:0]        pg;
  logic [CLS_W-1:0]  cls;
  logic              too_big;
  logic [6:0]        class_head [NUM_CLASSES];
  logic [NUM_PAGES-1:0] in_use;
  logic [6:0]        scan;
  logic [SLOT_W-1:0] thr;
  logic [SLOT_W-1:0] p_fc, p_bh, b;
  logic [6:0]        p_link;
  logic [11:0]       rem;
  logic [SLOT_W-1:0] q;
  logic [2:0]        k;
  logic [6:0]        walk, splice, steps;
  status_t           res_status;
  logic [17:0]       res_addr;
  logic              out_valid;
  status_t           out_status;
  logic [17:0]       out_addr;

  logic              p_we, b_we;
  logic [PW-1:0]     p_waddr, p_raddr;
  logic [BW-1:0]     b_waddr, b_raddr;
  page_entry_t       p_wdata, p_rdata;
  block_entry_t      b_wdata, b_rdata;

  scba_ram #(.WIDTH($bits(page_entry_t)), .DEPTH(NUM_PAGES)) u_page_ram (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
    .raddr(p_raddr), .rdata(p_rdata)
  );
  scba_ram #(.WIDTH($bits(block_entry_t)), .DEPTH(NUM_PAGES * 128)) u_block_ram (
    .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
    .raddr(b_raddr), .rdata(b_rdata)
  );

  logic [11:0]       bs;
  logic [SLOT_W-1:0] cnt;
  logic [18:0]       trial;
  logic              ge;
  logic [SLOT_W-1:0] pop_fc, push_fc;
  logic [6:0]        h_old, l1, h1;
  logic              full;
  logic [18:0]       prod;
  logic [19:0]       alloc_addr;

  always_comb begin
    bs      = BLK_SIZE[cls];
    cnt     = BLK_COUNT[cls];
    trial   = {7'b0, bs} << k;
    ge      = {7'b0, rem} >= trial;
    pop_fc  = p_fc - 7'd1;
    push_fc = p_fc + 7'd1;
    h_old   = class_head[cls];
    l1      = (push_fc == 7'd1) ? h_old : p_link;
    h1      = (push_fc == 7'd1) ? pg : h_old;
    full    = push_fc == cnt;
    prod    = {12'b0, b} * {7'b0, bs};
    alloc_addr = {1'b0, pg, 12'b0} + {8'b0, DATA_OFS} + {1'b0, prod};
  end

  // Memory port steering
  always_comb begin
    p_we    = 1'b0;
    p_waddr = pg[PW-1:0];
    p_wdata = p_rdata;
    b_we    = 1'b0;
    b_waddr = {pg[PW-1:0], thr};
    b_wdata = b_rdata;
    p_raddr = (cmd.op == OP_WALK_RD) ? walk[PW-1:0] : pg[PW-1:0];
    b_raddr = (cmd.op == OP_BLK_RD_HEAD) ? {pg[PW-1:0], p_rdata.block_head}
                                         : {pg[PW-1:0], q};
    case (cmd.op)
      OP_THREAD: begin
        b_we = 1'b1;
        b_wdata.link   = ({1'b0, thr} + 8'd1 < {1'b0, cnt}) ? thr + 7'd1 : NONE_PTR;
        b_wdata.used   = 1'b0;
        b_wdata.length = '0;
      end
      OP_LINK_NEW: begin
        p_we = 1'b1;
        p_wdata = '{cls: cls, free_count: cnt, block_head: '0, link: h_old};
      end
      OP_POP: begin
        p_we = 1'b1;
        p_wdata = '{cls: cls, free_count: pop_fc, block_head: b_rdata.link,
                    link: (pop_fc == 7'd0) ? NONE_PTR : p_link};
        b_we    = 1'b1;
        b_waddr = {pg[PW-1:0], b};
        b_wdata = '{link: b_rdata.link, used: 1'b1, length: size_q};
      end
      OP_PUSH: begin
        p_we = 1'b1;
        p_wdata = '{cls: cls, free_count: push_fc, block_head: b,
                    link: full ? NONE_PTR : l1};
        b_we    = 1'b1;
        b_waddr = {pg[PW-1:0], b};
        b_wdata = '{link: p_bh, used: 1'b0, length: b_rdata.length};
      end
      OP_WALK_FIX: begin
        p_we    = 1'b1;
        p_waddr = walk[PW-1:0];
        p_wdata.link = splice;
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      in_use    <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < NUM_CLASSES; i++) class_head[i] <= NONE_PTR;
    end else begin
      if (rsp.ready) out_valid <= 1'b0;
      case (cmd.op)
        OP_LINK_NEW: begin
          class_head[cls]   <= pg;
          in_use[pg[PW-1:0]] <= 1'b1;
        end
        OP_POP: if (pop_fc == 7'd0) class_head[cls] <= p_link;
        OP_PUSH: begin
          class_head[cls] <= (full && h1 == pg) ? l1 : h1;
          if (full) in_use[pg[PW-1:0]] <= 1'b0;
        end
        OP_RESULT: out_valid <= 1'b1;
        default: ;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LATCH: begin
        size_q  <= req.size_bytes;
        addr_q  <= req.block_address;
        pg      <= {1'b0, req.block_address[17:12]};
        cls     <= class_of(req.size_bytes);
        too_big <= ({1'b0, req.size_bytes} + HDR_BYTES) > MAX_NEED;
      end
      OP_ERR: begin
        res_status <= cmd.err;
        res_addr   <= '0;
      end
      OP_SEL_HEAD:   pg <= class_head[cls];
      OP_SCAN_START: scan <= '0;
      OP_SCAN_NEXT:  scan <= scan + 7'd1;
      OP_SCAN_HIT: begin
        pg  <= scan;
        thr <= '0;
      end
      OP_THREAD: thr <= thr + 7'd1;
      OP_BLK_RD_HEAD: begin
        p_fc   <= p_rdata.free_count;
        p_bh   <= p_rdata.block_head;
        p_link <= p_rdata.link;
        b      <= p_rdata.block_head;
      end
      OP_POP: begin
        res_status <= ST_OK;
        res_addr   <= alloc_addr[17:0];
      end
      OP_CAP_PAGE: begin
        cls    <= p_rdata.cls;
        p_fc   <= p_rdata.free_count;
        p_bh   <= p_rdata.block_head;
        p_link <= p_rdata.link;
        rem    <= addr_q[11:0] - DATA_OFS;
        q      <= '0;
        k      <= 3'd6;
      end
      OP_DIV_STEP: begin
        if (ge) rem <= rem - trial[11:0];
        q <= {q[SLOT_W-2:0], ge};
        k <= k - 3'd1;
      end
      OP_BLK_RD_Q: b <= q;
      OP_PUSH: begin
        res_status <= ST_OK;
        res_addr   <= '0;
        splice     <= l1;
        walk       <= h1;
        steps      <= '0;
      end
      OP_WALK_NEXT: begin
        walk  <= p_rdata.link;
        steps <= steps + 7'd1;
      end
      OP_RESULT: begin
        out_status <= res_status;
        out_addr   <= res_addr;
      end
      default: ;
    endcase
  end

  always_comb begin
    st.req_valid  = req.valid;
    st.req_free   = req.mode;
    st.too_big    = too_big;
    st.head_none  = class_head[cls] == NONE_PTR;
    st.scan_free  = !in_use[scan[PW-1:0]];
    st.scan_last  = scan == NP - 7'd1;
    st.thr_last   = thr == cnt - 7'd1;
    st.pg_ok      = (pg < NP) && in_use[pg[PW-1:0]];
    st.off_low    = addr_q[11:0] < DATA_OFS;
    st.div_last   = k == 3'd0;
    st.div_bad    = (rem != 12'd0) || (q >= cnt);
    st.blk_unused = !b_rdata.used;
    st.len_bad    = (size_q != 13'd0) && (size_q != b_rdata.length);
    st.need_walk  = full && (h1 != pg);
    st.walk_end   = (walk >= NP) || (steps >= NP);
    st.walk_hit   = p_rdata.link == pg;
    st.out_free   = !out_valid || rsp.ready;
  end

  assign req.ready   = in_ready;
  assign rsp.valid   = out_valid;
  assign rsp.status  = out_status;
  assign rsp.address = out_addr;
endmodule
`default_nettype wire

[rtl/scba_ctrl.sv]
// Allocator sequencer: walks each request through its datapath micro-ops.
// Depends on scba_pkg.
`default_nettype none
module scba_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire scba_pkg::stat_t st,
  output scba_pkg::cmd_t       cmd,
  output logic                 in_ready
);
  import scba_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:     if (st.req_valid) state_next = st.req_free ? S_F_CHK : S_A_HEAD;
      S_A_HEAD:   state_next = st.too_big ? S_DONE : (st.head_none ? S_A_SCAN : S_A_PRD);
      S_A_SCAN:   if (st.scan_free) state_next = S_A_THREAD;
                  else if (st.scan_last) state_next = S_DONE;
      S_A_THREAD: if (st.thr_last) state_next = S_A_LINK;
      S_A_LINK:   state_next = S_A_PRD;
      S_A_PRD:    state_next = S_A_BRD;
      S_A_BRD:    state_next = S_A_POP;
      S_A_POP:    state_next = S_DONE;
      S_F_CHK:    state_next = st.pg_ok ? S_F_PAGE : S_DONE;
      S_F_PAGE:   state_next = S_F_DIV;
      S_F_DIV:    if (st.off_low) state_next = S_DONE;
                  else if (st.div_last) state_next = S_F_DCHK;
      S_F_DCHK:   state_next = st.div_bad ? S_DONE : S_F_BLK;
      S_F_BLK:    state_next = (!st.blk_unused && !st.len_bad && st.need_walk)
                               ? S_F_WRD : S_DONE;
      S_F_WRD:    state_next = st.walk_end ? S_DONE : S_F_WCHK;
      S_F_WCHK:   state_next = st.walk_hit ? S_DONE : S_F_WRD;
      S_DONE:     if (st.out_free) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd.op   = OP_NONE;
    cmd.err  = ST_OK;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (st.req_valid) cmd.op = OP_LATCH;
      end
      S_A_HEAD:
        if (st.too_big) begin
          cmd.op = OP_ERR; cmd.err = ST_TOO_LARGE;
        end else cmd.op = st.head_none ? OP_SCAN_START : OP_SEL_HEAD;
      S_A_SCAN:
        if (st.scan_free) cmd.op = OP_SCAN_HIT;
        else if (st.scan_last) begin
          cmd.op = OP_ERR; cmd.err = ST_NO_PAGE;
        end else cmd.op = OP_SCAN_NEXT;
      S_A_THREAD: cmd.op = OP_THREAD;
      S_A_LINK:   cmd.op = OP_LINK_NEW;
      S_A_PRD:    cmd.op = OP_PAGE_RD;
      S_A_BRD:    cmd.op = OP_BLK_RD_HEAD;
      S_A_POP:    cmd.op = OP_POP;
      S_F_CHK:
        if (st.pg_ok) cmd.op = OP_PAGE_RD;
        else begin
          cmd.op = OP_ERR; cmd.err = ST_BAD_POINTER;
        end
      S_F_PAGE:   cmd.op = OP_CAP_PAGE;
      S_F_DIV:
        if (st.off_low) begin
          cmd.op = OP_ERR; cmd.err = ST_BAD_POINTER;
        end else cmd.op = OP_DIV_STEP;
      S_F_DCHK:
        if (st.div_bad) begin
          cmd.op = OP_ERR; cmd.err = ST_BAD_POINTER;
        end else cmd.op = OP_BLK_RD_Q;
      S_F_BLK:
        if (st.blk_unused) begin
          cmd.op = OP_ERR; cmd.err = ST_BAD_POINTER;
        end else if (st.len_bad) begin
          cmd.op = OP_ERR; cmd.err = ST_SIZE_MISMATCH;
        end else cmd.op = OP_PUSH;
      S_F_WRD:    if (!st.walk_end) cmd.op = OP_WALK_RD;
      S_F_WCHK:   cmd.op = st.walk_hit ? OP_WALK_FIX : OP_WALK_NEXT;
      S_DONE:     if (st.out_free) cmd.op = OP_RESULT;
      default: ;
    endcase
  end
endmodule
`default_nettype wire

[rtl/size_class_block_allocator_unit.sv]
// Top level of the size class block allocator: sequencer plus datapath.
// Depends on scba_pkg, the channel interfaces, scba_ctrl and scba_datapath.
//
//  channel | dir | payload                            | transfer when
//  --------+-----+------------------------------------+--------------------
//  req     | in  | mode, size_bytes, block_address    | req.valid & req.ready
//  rsp     | out | status, address                    | rsp.valid & rsp.ready
//
// One request is in flight at a time; req.ready is high only while idle.
// Allocate from a partly free page reads the list head page, then its head
// block, then pops that block. Allocate that opens a page first scans for the
// lowest free page (up to NUM_PAGES pages), threads its blocks one at a time
// (up to 127) through the single block RAM write port and links the page in.
// Free turns the page offset into a slot with the 7-step restoring divider,
// then walks the class list page by page to unlink a page that becomes wholly
// free.
// Reset is synchronous and needs no clearing pass; per-page and per-block
// tables are written before they are ever read. A stalled rsp holds the
// finished result in its output register; the next request is taken meanwhile.
`default_nettype none
module size_class_block_allocator_unit #(
  parameter int NUM_PAGES = scba_pkg::NUM_PAGES_DEF
) (
  input wire logic   clk,
  input wire logic   rst,
  scba_req_if.sink   req,
  scba_rsp_if.source rsp
);
  import scba_pkg::*;

  cmd_t  cmd;   // micro-op from the sequencer
  stat_t st;    // decision flags back from the datapath
  logic  in_ready;

  // Sequencer: decide the next micro-op from datapath flags
  scba_ctrl u_ctrl (
    .clk(clk), .rst(rst), .st(st), .cmd(cmd), .in_ready(in_ready)
  );

  // Datapath: tables, list heads, divider and result registers
  scba_datapath #(.NUM_PAGES(NUM_PAGES)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .in_ready(in_ready), .st(st),
    .req(req), .rsp(rsp)
  );
endmodule
`default_nettype wire

[rtl/scba_checker.sv]
// Port-level checks for the allocator, bound to the top level.
// Depends on scba_pkg.
`default_nettype none
module scba_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        req_valid,
  input wire logic        req_ready,
  input wire logic        rsp_valid,
  input wire logic        rsp_ready,
  input wire logic [2:0]  rsp_status,
  input wire logic [17:0] rsp_address
);
  import scba_pkg::*;

  // One request at a time: ready drops right after a transfer
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready) else $error("ready after transfer");

  a_err_addr_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status != ST_OK |-> rsp_address == 18'd0)
    else $error("failed result with address");

  a_addr_in_data: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_address != 18'd0 |->
      rsp_status == ST_OK && rsp_address[11:0] >= DATA_OFS)
    else $error("address outside block data");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_address)) else $error("stalled result changed");
endmodule

bind size_class_block_allocator_unit scba_checker u_scba_checker (
  .clk(clk), .rst(rst),
  .req_valid(req.valid), .req_ready(req.ready),
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
  .rsp_status(rsp.status), .rsp_address(rsp.address)
);
`default_nettype wire
